/* rtl/shwm_pkg.sv */
// Package for the sequence Hamming window matcher.
// Beat types, action and register codes, field widths and reset defaults.
// No dependencies; every rtl file imports it.
package shwm_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAP_DEPTH_DEF  = 64;
    localparam int WINDOW_MAX_DEF = 16;
    localparam int DESC_BITS_DEF  = 64;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 6;
    localparam int DESC_W   = 64;
    localparam int SHIFT_W  = 6;
    localparam int DIST_W   = 11;
    localparam int DIST_MAX = 2047;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int WLEN_W     = 5;
    localparam int MLEN_W     = 7;
    localparam int THR_W      = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LENGTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 2'd2;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd8;
    localparam logic [MLEN_W-1:0] MLEN_RESET = 7'd64;
    localparam logic [THR_W-1:0]  THR_RESET  = 11'd0;

    // Input actions
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TEST  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  map_index;
        logic [DESC_W-1:0]   descriptor;
    } t_in_beat;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [DIST_W-1:0]  distance;
        logic               is_match;
        logic               last;
    } t_out_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic map_wr;        // write map entry from the accepted beat
        logic win_push;      // push accepted descriptor into the window
        logic op_valid;      // one distance term issued this cycle
        logic op_incr;       // incremental update: prev + new pair - old pair
        logic op_first;      // first term of a direct sum
        logic op_last;       // term closes a shift: emit result
        logic op_item_last;  // final shift of the item
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;     // terms still in flight
        logic room;          // result queue can take one more shift
    } t_status;

endpackage

/* rtl/shwm_ctrl.sv */
// Controller for the sequence Hamming window matcher.
// Holds configuration, window fill, sums-valid flag and the shift/term sequencer.
// Depends on shwm_pkg.
module shwm_ctrl #(
    parameter int MAP_DEPTH  = shwm_pkg::MAP_DEPTH_DEF,
    parameter int WINDOW_MAX = shwm_pkg::WINDOW_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [shwm_pkg::ACTION_W-1:0]     i_action,
    input  logic [shwm_pkg::INDEX_W-1:0]      i_map_index,
    input  logic                              i_cfg_we,
    input  logic [shwm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [shwm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  shwm_pkg::t_status                 i_status,
    output shwm_pkg::t_cmd                    o_cmd,
    output logic [$clog2(MAP_DEPTH)-1:0]      o_map_a,
    output logic [$clog2(MAP_DEPTH)-1:0]      o_map_b,
    output logic [$clog2(WINDOW_MAX+1)-1:0]   o_win_sel,
    output logic [$clog2(MAP_DEPTH)-1:0]      o_shift,
    output logic [shwm_pkg::THR_W-1:0]        o_threshold
);
    import shwm_pkg::*;

    localparam int AW  = $clog2(MAP_DEPTH);
    localparam int WSW = $clog2(WINDOW_MAX + 1);
    localparam int MW  = $clog2(MAP_DEPTH + 1);
    localparam int KW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state              r_state;
    logic [WLEN_W-1:0]   r_wlen;
    logic [MLEN_W-1:0]   r_mlen;
    logic [THR_W-1:0]    r_thr;
    logic [WSW-1:0]      r_fill;
    logic                r_sums_valid;
    logic                r_incr;
    logic [WSW-1:0]      r_len;
    logic [AW-1:0]       r_s;
    logic [AW-1:0]       r_last_s;
    logic [KW-1:0]       r_k;

    logic [WSW-1:0]      elen;
    logic [MW-1:0]       emap;
    logic [WSW-1:0]      n_fill;
    logic                accept;
    logic                direct;
    logic                issue;

    // Clamp the length registers into their usable range
    always_comb begin
        if (r_wlen == '0) begin
            elen = WSW'(1);
        end else if (int'(r_wlen) > WINDOW_MAX) begin
            elen = WSW'(WINDOW_MAX);
        end else begin
            elen = WSW'(r_wlen);
        end
        if (r_mlen == '0) begin
            emap = MW'(1);
        end else if (int'(r_mlen) > MAP_DEPTH) begin
            emap = MW'(MAP_DEPTH);
        end else begin
            emap = MW'(r_mlen);
        end
        n_fill = (r_fill >= elen) ? elen : WSW'(int'(r_fill) + 1);
    end

    assign o_in_stall = (r_state != ST_IDLE) || i_status.pipe_busy;
    assign accept     = i_in_valid && !o_in_stall;

    // Term generation: direct sum over the window, or one incremental step
    always_comb begin
        direct = !r_incr || (r_s == '0);
        o_cmd  = '0;
        o_cmd.map_wr   = accept && (i_action == ACT_LOAD) && (int'(i_map_index) < MAP_DEPTH);
        o_cmd.win_push = accept && (i_action == ACT_TEST);
        o_map_b   = AW'(int'(r_s) - 1);
        o_shift   = r_s;
        if (direct) begin
            o_map_a        = AW'(int'(r_s) + int'(r_k));
            o_win_sel      = WSW'(int'(r_len) - 1 - int'(r_k));
            o_cmd.op_incr  = 1'b0;
            o_cmd.op_first = (r_k == '0);
            o_cmd.op_last  = (int'(r_k) == int'(r_len) - 1);
        end else begin
            o_map_a        = AW'(int'(r_s) + int'(r_len) - 1);
            o_win_sel      = r_len;
            o_cmd.op_incr  = 1'b1;
            o_cmd.op_first = 1'b1;
            o_cmd.op_last  = 1'b1;
        end
        o_cmd.op_item_last = o_cmd.op_last && (r_s == r_last_s);
        issue              = (r_state == ST_RUN) && (!o_cmd.op_last || i_status.room);
        o_cmd.op_valid     = issue;
        o_threshold        = r_thr;
    end

    // State, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wlen       <= WLEN_RESET;
            r_mlen       <= MLEN_RESET;
            r_thr        <= THR_RESET;
            r_fill       <= '0;
            r_sums_valid <= 1'b0;
            r_incr       <= 1'b0;
            r_len        <= '0;
            r_s          <= '0;
            r_last_s     <= '0;
            r_k          <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_action)
                            ACT_LOAD: begin
                                if (int'(i_map_index) < MAP_DEPTH) begin
                                    r_sums_valid <= 1'b0;
                                end
                            end
                            ACT_TEST: begin
                                r_fill <= n_fill;
                                if (n_fill == elen) begin
                                    if (int'(emap) < int'(elen)) begin
                                        r_sums_valid <= 1'b0;
                                    end else begin
                                        r_state  <= ST_RUN;
                                        r_s      <= '0;
                                        r_k      <= '0;
                                        r_len    <= elen;
                                        r_last_s <= AW'(int'(emap) - int'(elen));
                                        r_incr   <= r_sums_valid;
                                    end
                                end
                            end
                            ACT_CLEAR: begin
                                r_fill       <= '0;
                                r_sums_valid <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        if (o_cmd.op_last) begin
                            r_k <= '0;
                            if (o_cmd.op_item_last) begin
                                r_state      <= ST_IDLE;
                                r_sums_valid <= 1'b1;
                            end else begin
                                r_s <= AW'(int'(r_s) + 1);
                            end
                        end else begin
                            r_k <= KW'(int'(r_k) + 1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // Register writes are to arrive only while idle; the block itself does not enforce it
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW_LENGTH: begin
                        r_wlen       <= i_cfg_wdata[WLEN_W-1:0];
                        r_fill       <= '0;
                        r_sums_valid <= 1'b0;
                    end
                    CFG_MAP_LENGTH: begin
                        r_mlen       <= i_cfg_wdata[MLEN_W-1:0];
                        r_sums_valid <= 1'b0;
                    end
                    CFG_MATCH_THRESHOLD: begin
                        r_thr <= i_cfg_wdata[THR_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

/* rtl/shwm_datapath.sv */
// Datapath for the sequence Hamming window matcher.
// Map store, window shift line, per-shift sum memory, popcount pipeline, result queue.
// Depends on shwm_pkg; driven by shwm_ctrl.
module shwm_datapath #(
    parameter int MAP_DEPTH  = shwm_pkg::MAP_DEPTH_DEF,
    parameter int WINDOW_MAX = shwm_pkg::WINDOW_MAX_DEF,
    parameter int DESC_BITS  = shwm_pkg::DESC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  shwm_pkg::t_cmd                    i_cmd,
    input  logic [$clog2(MAP_DEPTH)-1:0]      i_map_a,
    input  logic [$clog2(MAP_DEPTH)-1:0]      i_map_b,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]   i_win_sel,
    input  logic [$clog2(MAP_DEPTH)-1:0]      i_shift,
    input  logic [shwm_pkg::THR_W-1:0]        i_threshold,
    input  logic [shwm_pkg::INDEX_W-1:0]      i_map_index,
    input  logic [shwm_pkg::DESC_W-1:0]       i_descriptor,
    output shwm_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output shwm_pkg::t_out_beat               o_out
);
    import shwm_pkg::*;

    localparam int AW         = $clog2(MAP_DEPTH);
    localparam int SUM_W      = $clog2(WINDOW_MAX * DESC_BITS + 1);
    localparam int SW1        = SUM_W + 1;
    localparam int PW         = $clog2(DESC_BITS + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FPW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);

    function automatic logic [PW-1:0] f_popcount(input logic [DESC_BITS-1:0] v);
        logic [PW-1:0] n;
        n = '0;
        for (int i = 0; i < DESC_BITS; i++) begin
            n = n + PW'(v[i]);
        end
        return n;
    endfunction

    // Storage
    logic [DESC_BITS-1:0] r_map  [MAP_DEPTH];
    logic [DESC_BITS-1:0] r_win  [WINDOW_MAX+1];
    logic [SUM_W-1:0]     r_prev [2*MAP_DEPTH];
    logic                 r_bank;

    // Stage 1: memory reads
    logic                 r_p1_valid;
    logic                 r_p1_incr;
    logic                 r_p1_first;
    logic                 r_p1_last;
    logic                 r_p1_item_last;
    logic [AW-1:0]        r_p1_shift;
    logic [DESC_BITS-1:0] r_rd_a;
    logic [DESC_BITS-1:0] r_rd_b;
    logic [DESC_BITS-1:0] r_w_var;
    logic [DESC_BITS-1:0] r_w_new;
    logic [SUM_W-1:0]     r_prev_q;

    // Stage 2: popcounts
    logic                 r_p2_valid;
    logic                 r_p2_incr;
    logic                 r_p2_first;
    logic                 r_p2_last;
    logic                 r_p2_item_last;
    logic [AW-1:0]        r_p2_shift;
    logic [PW-1:0]        r_pop_a;
    logic [PW-1:0]        r_pop_b;
    logic [SUM_W-1:0]     r_prev2;

    // Stage 3: accumulate
    logic [SUM_W-1:0]     r_acc;
    logic [SUM_W-1:0]     n_sum;
    t_out_beat            n_beat;

    // Result queue
    t_out_beat            r_fifo [FIFO_DEPTH];
    logic [FPW-1:0]       r_wr_ptr;
    logic [FPW-1:0]       r_rd_ptr;
    logic [FCW-1:0]       r_cnt;
    logic                 push;
    logic                 pop;

    // Map store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.map_wr) begin
            r_map[i_map_index[AW-1:0]] <= i_descriptor[DESC_BITS-1:0];
        end
        r_rd_a <= r_map[i_map_a];
        r_rd_b <= r_map[i_map_b];
    end

    // Window shift line, newest at slot 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.win_push) begin
            r_win[0] <= i_descriptor[DESC_BITS-1:0];
            for (int i = 1; i <= WINDOW_MAX; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
        r_w_var <= r_win[i_win_sel];
        r_w_new <= r_win[0];
    end

    // Per-shift sums, two banks: read last item's bank, write the other
    always_ff @(posedge i_clk) begin
        if (r_p2_valid && r_p2_last) begin
            r_prev[{~r_bank, r_p2_shift}] <= n_sum;
        end
        r_prev_q <= r_prev[{r_bank, i_map_b}];
    end

    // Stage 2 and 3 payload
    always_ff @(posedge i_clk) begin
        r_pop_a <= f_popcount((r_p1_incr ? r_w_new : r_w_var) ^ r_rd_a);
        r_pop_b <= f_popcount(r_w_var ^ r_rd_b);
        r_prev2 <= r_prev_q;
        if (r_p2_valid) begin
            r_acc <= n_sum;
        end
    end

    // Sum update and result beat
    always_comb begin
        if (r_p2_incr) begin
            n_sum = SUM_W'(({1'b0, r_prev2} + SW1'(r_pop_a)) - SW1'(r_pop_b));
        end else begin
            n_sum = (r_p2_first ? '0 : r_acc) + SUM_W'(r_pop_a);
        end
        n_beat.shift    = SHIFT_W'(r_p2_shift);
        n_beat.distance = (int'(n_sum) > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(n_sum);
        n_beat.is_match = int'(n_sum) < int'(i_threshold);
        n_beat.last     = r_p2_item_last;
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_bank     <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.op_valid;
            r_p2_valid <= r_p1_valid;
            if (r_p2_valid && r_p2_item_last) begin
                r_bank <= ~r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_incr      <= i_cmd.op_incr;
        r_p1_first     <= i_cmd.op_first;
        r_p1_last      <= i_cmd.op_last;
        r_p1_item_last <= i_cmd.op_item_last;
        r_p1_shift     <= i_shift;
        r_p2_incr      <= r_p1_incr;
        r_p2_first     <= r_p1_first;
        r_p2_last      <= r_p1_last;
        r_p2_item_last <= r_p1_item_last;
        r_p2_shift     <= r_p1_shift;
    end

    // Result queue; credits cover shifts still in the pipeline
    assign push        = r_p2_valid && r_p2_last;
    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out       = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= FPW'(int'(r_wr_ptr) + 1);
            end
            if (pop) begin
                r_rd_ptr <= FPW'(int'(r_rd_ptr) + 1);
            end
            r_cnt <= FCW'(int'(r_cnt) + int'(push) - int'(pop));
        end
    end

    always_comb begin
        o_status.pipe_busy = r_p1_valid || r_p2_valid;
        o_status.room      = (int'(r_cnt) + int'(r_p1_valid && r_p1_last)
                              + int'(r_p2_valid && r_p2_last)) < FIFO_DEPTH;
    end

endmodule

/* rtl/sequence_hamming_window_matcher_top.sv */
// Top level of the sequence Hamming window matcher.
// Joins shwm_ctrl and shwm_datapath; depends on shwm_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in) takes one beat per item:
//   load a map entry, test a descriptor, or clear the window. Output channel
//   (o_out_valid / i_out_stall, payload o_out) gives one beat per alignment shift
//   of a test item once the window is full; the final beat of the item has last set.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata while idle.
// Throughput:
//   Load, clear and non-emitting test beats do not hold the input. A test item that
//   emits holds it: with sums of the previous item reused, shift 0 is summed term by
//   term, then one shift per cycle while the result queue has room; else every shift
//   is summed directly over the whole window (first full window, after a map load or
//   length change). One popcount pair per cycle, while the queue has room, enters a
//   three-stage read/popcount/accumulate pipeline that drains before the next item.
// Reset: window empty, stored sums invalid, registers at defaults; map contents
//   are undefined until loaded.
// Stall: a four-beat result queue sits before the output; when the receiver stalls,
//   issue of new shifts pauses and no result is lost.
module sequence_hamming_window_matcher_top #(
    parameter int MAP_DEPTH  = shwm_pkg::MAP_DEPTH_DEF,
    parameter int WINDOW_MAX = shwm_pkg::WINDOW_MAX_DEF,
    parameter int DESC_BITS  = shwm_pkg::DESC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  shwm_pkg::t_in_beat                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output shwm_pkg::t_out_beat               o_out,
    input  logic                              i_cfg_we,
    input  logic [shwm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [shwm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import shwm_pkg::*;

    localparam int AW  = $clog2(MAP_DEPTH);
    localparam int WSW = $clog2(WINDOW_MAX + 1);

    t_cmd              cmd;
    t_status           status;
    logic [AW-1:0]     map_a;
    logic [AW-1:0]     map_b;
    logic [WSW-1:0]    win_sel;
    logic [AW-1:0]     shift;
    logic [THR_W-1:0]  threshold;

    shwm_ctrl #(
        .MAP_DEPTH  (MAP_DEPTH),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_in.action),
        .i_map_index (i_in.map_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_map_a     (map_a),
        .o_map_b     (map_b),
        .o_win_sel   (win_sel),
        .o_shift     (shift),
        .o_threshold (threshold)
    );

    shwm_datapath #(
        .MAP_DEPTH  (MAP_DEPTH),
        .WINDOW_MAX (WINDOW_MAX),
        .DESC_BITS  (DESC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_map_a      (map_a),
        .i_map_b      (map_b),
        .i_win_sel    (win_sel),
        .i_shift      (shift),
        .i_threshold  (threshold),
        .i_map_index  (i_in.map_index),
        .i_descriptor (i_in.descriptor),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule

/* tb/tb_sequence_hamming_window_matcher_top.sv */
// Testbench for sequence_hamming_window_matcher_top: directed and random beats,
// each shift result checked against an in-bench predictor of the window sums.
// Depends on shwm_pkg and the rtl top level only.
`timescale 1ns / 100ps

module tb_sequence_hamming_window_matcher_top;
    import shwm_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 220;

    // Action code the block ignores
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // DUT drive and observe
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_beat;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state
    logic [DESC_W-1:0] pred_map [0:63];
    logic [DESC_W-1:0] pred_win [0:16];
    int                pred_fill = 0;
    bit                pred_sums_ok = 1'b0;
    int                pred_prev [0:63];
    logic [WLEN_W-1:0] pred_wlen = WLEN_RESET;
    logic [MLEN_W-1:0] pred_mlen = MLEN_RESET;
    logic [THR_W-1:0]  pred_thr = THR_RESET;

    // Expected shift results, oldest first
    t_out_beat align_q [$];
    t_out_beat want_beat;

    // Bookkeeping
    int  mismatch_cnt = 0;
    int  beats_sent = 0;
    int  tests_sent = 0;
    int  random_items = 0;
    int  results_seen = 0;
    int  settings_cnt = 0;
    bit  calm = 1'b0;
    int  stall_hold = 0;
    int  stall_roll = 0;
    int  walk_pos = 0;

    sequence_hamming_window_matcher_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Window length as the block uses it
    function automatic int eff_wlen();
        if (pred_wlen == 0) return 1;
        if (pred_wlen > 16) return 16;
        return int'(pred_wlen);
    endfunction

    // Register write into the predictor copy
    task automatic pred_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WINDOW_LENGTH: begin
                pred_wlen    = data[WLEN_W-1:0];
                pred_fill    = 0;
                pred_sums_ok = 1'b0;
            end
            CFG_MAP_LENGTH: begin
                pred_mlen    = data[MLEN_W-1:0];
                pred_sums_ok = 1'b0;
            end
            CFG_MATCH_THRESHOLD: pred_thr = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    // Work out the shift results one accepted beat causes
    task automatic predict_alignments(input t_in_beat b);
        int        len;
        int        mlen;
        int        cnt;
        int        d;
        int        sums [0:63];
        t_out_beat r;
        case (b.action)
            ACT_LOAD: begin
                pred_map[b.map_index] = b.descriptor;
                pred_sums_ok = 1'b0;
            end
            ACT_CLEAR: begin
                pred_fill    = 0;
                pred_sums_ok = 1'b0;
            end
            ACT_TEST: begin
                len = eff_wlen();
                // slide or grow the window; slot 0 keeps the descriptor that left
                if (pred_fill >= len) begin
                    for (int k = 0; k < len; k++) pred_win[k] = pred_win[k+1];
                    pred_win[len] = b.descriptor;
                    pred_fill = len;
                end else begin
                    pred_fill++;
                    pred_win[pred_fill] = b.descriptor;
                end
                if (pred_fill >= len) begin
                    mlen = (pred_mlen == 0) ? 1 : (pred_mlen > 64) ? 64 : int'(pred_mlen);
                    if (mlen < len) begin
                        pred_sums_ok = 1'b0;
                    end else begin
                        cnt = mlen - len + 1;
                        for (int s = 0; s < cnt; s++) begin
                            if (pred_sums_ok && s != 0) begin
                                d = pred_prev[s-1]
                                    + $countones(pred_win[len] ^ pred_map[s+len-1])
                                    - $countones(pred_win[0] ^ pred_map[s-1]);
                            end else begin
                                d = 0;
                                for (int k = 0; k < len; k++)
                                    d += $countones(pred_win[k+1] ^ pred_map[s+k]);
                            end
                            sums[s] = d;
                        end
                        for (int s = 0; s < cnt; s++) begin
                            pred_prev[s] = sums[s];
                            r.shift    = SHIFT_W'(s);
                            r.distance = (sums[s] > DIST_MAX) ? DIST_W'(DIST_MAX)
                                                              : DIST_W'(sums[s]);
                            r.is_match = (sums[s] < int'(pred_thr));
                            r.last     = (s == cnt - 1);
                            align_q = {align_q, r};
                        end
                        pred_sums_ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drive one beat and hold it until accepted
    task automatic send_beat(input t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
        if (b.action == ACT_TEST) tests_sent++;
        predict_alignments(b);
    endtask

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                             input logic [DESC_W-1:0] desc);
        t_in_beat b;
        b.action     = act;
        b.map_index  = idx;
        b.descriptor = desc;
        send_beat(b);
    endtask

    // Drop valid, let every expected result arrive, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (align_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        pred_reg_write(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [DESC_W-1:0] rand_desc();
        return {$urandom, $urandom};
    endfunction

    // Descriptor close to a map entry, so the window can line up with the map
    function automatic logic [DESC_W-1:0] near_map_desc(input int pos);
        logic [DESC_W-1:0] d;
        int                flips;
        d = pred_map[pos];
        flips = $urandom_range(0, 3);
        for (int j = 0; j < flips; j++) d[$urandom_range(0, DESC_W-1)] ^= 1'b1;
        return d;
    endfunction

    // Result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (align_q.size() == 0) begin
                $display("%0t unexpected result: shift %0d distance %0d match %0b last %0b",
                         $time, out_beat.shift, out_beat.distance, out_beat.is_match,
                         out_beat.last);
                mismatch_cnt++;
            end else begin
                want_beat = align_q.pop_front();
                if (out_beat.shift !== want_beat.shift) begin
                    $display("%0t shift: expected %0d actual %0d",
                             $time, want_beat.shift, out_beat.shift);
                    mismatch_cnt++;
                end
                if (out_beat.distance !== want_beat.distance) begin
                    $display("%0t distance at shift %0d: expected %0d actual %0d",
                             $time, want_beat.shift, want_beat.distance, out_beat.distance);
                    mismatch_cnt++;
                end
                if (out_beat.is_match !== want_beat.is_match) begin
                    $display("%0t is_match at shift %0d: expected %0b actual %0b",
                             $time, want_beat.shift, want_beat.is_match, out_beat.is_match);
                    mismatch_cnt++;
                end
                if (out_beat.last !== want_beat.last) begin
                    $display("%0t last at shift %0d: expected %0b actual %0b",
                             $time, want_beat.shift, want_beat.last, out_beat.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Receiver stall: runs of ready and stalled cycles, a few long stalls
    always @(posedge clk) begin
        if (calm) begin
            out_stall  <= 1'b0;
            stall_hold = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 55) begin
                out_stall  <= 1'b0;
                stall_hold = $urandom_range(0, 4);
            end else if (stall_roll < 93) begin
                out_stall  <= 1'b1;
                stall_hold = $urandom_range(0, 2);
            end else begin
                out_stall  <= 1'b1;
                stall_hold = $urandom_range(8, 30);
            end
        end
    end

    // Fill every map slot so no read ever meets an unloaded entry
    task automatic test_map_fill();
        for (int i = 0; i < 64; i++) begin
            if (i == 0)       send_item(ACT_LOAD, INDEX_W'(i), '0);
            else if (i == 1)  send_item(ACT_LOAD, INDEX_W'(i), {32{2'b10}});
            else if (i == 2)  send_item(ACT_LOAD, INDEX_W'(i), {32{2'b01}});
            else if (i == 63) send_item(ACT_LOAD, INDEX_W'(i), '1);
            else              send_item(ACT_LOAD, INDEX_W'(i), rand_desc());
        end
    endtask

    // Reset settings: window fills over seven silent tests, then direct and
    // incremental sums
    task automatic test_default_window();
        settings_cnt++;
        send_item(ACT_TEST, '0, '0);
        send_item(ACT_TEST, '1, '1);
        send_item(ACT_TEST, '0, {32{2'b10}});
        send_item(ACT_TEST, '1, {32{2'b01}});
        for (int i = 0; i < 5; i++) send_item(ACT_TEST, INDEX_W'(i), near_map_desc(20 + i));
        wait_idle();
    endtask

    // Zero lengths clamp to one, map shorter than window, widest map length
    task automatic test_register_clamps();
        settings_cnt += 3;
        write_reg(CFG_WINDOW_LENGTH, '0);
        write_reg(CFG_MAP_LENGTH, '0);
        write_reg(CFG_MATCH_THRESHOLD, '1);
        send_item(ACT_TEST, '0, rand_desc());
        send_item(ACT_TEST, '0, '1);
        wait_idle();
        write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(3));
        write_reg(CFG_MAP_LENGTH, CFG_DATA_W'(2));
        for (int i = 0; i < 3; i++) send_item(ACT_TEST, '0, rand_desc());
        wait_idle();
        // full window kept, map length change forces a direct sum
        write_reg(CFG_MAP_LENGTH, CFG_DATA_W'(127));
        send_item(ACT_TEST, '0, near_map_desc(40));
        send_item(ACT_TEST, '0, near_map_desc(41));
        wait_idle();
    endtask

    // Clear empties the window, unknown action does nothing, a load makes sums stale
    task automatic test_clear_and_unknown();
        settings_cnt++;
        write_reg(CFG_MATCH_THRESHOLD, CFG_DATA_W'(1025));
        send_item(ACT_CLEAR, '1, rand_desc());
        send_item(ACT_UNUSED, INDEX_W'($urandom), rand_desc());
        for (int i = 0; i < 3; i++) send_item(ACT_TEST, '0, near_map_desc(10 + i));
        send_item(ACT_LOAD, INDEX_W'(62), rand_desc());
        send_item(ACT_TEST, '0, near_map_desc(13));
        wait_idle();
    endtask

    // Register settings for one random phase; the first few are the extremes
    task automatic set_phase_regs(input int phase);
        logic [CFG_DATA_W-1:0] wl;
        logic [CFG_DATA_W-1:0] ml;
        logic [CFG_DATA_W-1:0] th;
        int                    start;
        int                    j;
        int                    len;
        case (phase)
            0: begin
                wl = CFG_DATA_W'(31);
                ml = CFG_DATA_W'(127);
                th = CFG_DATA_W'($urandom_range(0, 2047));
            end
            1: begin
                wl = CFG_DATA_W'(16);
                ml = CFG_DATA_W'(16);
                th = CFG_DATA_W'(1025);
            end
            2: begin
                wl = '0;
                ml = CFG_DATA_W'(64);
                th = '0;
            end
            3: begin
                wl = CFG_DATA_W'(1);
                ml = CFG_DATA_W'(1);
                th = CFG_DATA_W'(2047);
            end
            default: begin
                wl = CFG_DATA_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 6)
                                                            : $urandom_range(0, 31));
                ml = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(1, 64));
                len = (wl == 0) ? 1 : (wl > 16) ? 16 : int'(wl);
                th = CFG_DATA_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, len * 40)
                                                            : $urandom_range(0, 2047));
            end
        endcase
        start = $urandom_range(0, 2);
        for (j = 0; j < 3; j++) begin
            if (phase < 4 || $urandom_range(0, 4) != 0) begin
                case ((start + j) % 3)
                    0:       write_reg(CFG_WINDOW_LENGTH, wl);
                    1:       write_reg(CFG_MAP_LENGTH, ml);
                    default: write_reg(CFG_MATCH_THRESHOLD, th);
                endcase
            end
        end
        settings_cnt++;
    endtask

    // Random phases: mostly tests that walk along the map, some loads, clears, noise
    task automatic test_random_traffic();
        int phase;
        int n;
        int r;
        int mlen;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            set_phase_regs(phase);
            calm = ($urandom_range(0, 4) == 0);
            mlen = (pred_mlen == 0) ? 1 : (pred_mlen > 64) ? 64 : int'(pred_mlen);
            walk_pos = $urandom_range(0, mlen - 1);
            n = eff_wlen() + $urandom_range(2, 12);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 84) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_item(ACT_TEST, INDEX_W'($urandom), near_map_desc(walk_pos % mlen));
                    end else begin
                        send_item(ACT_TEST, INDEX_W'($urandom), rand_desc());
                    end
                    walk_pos++;
                    random_items++;
                end else if (r < 90) begin
                    send_item(ACT_LOAD, INDEX_W'($urandom), rand_desc());
                    random_items++;
                end else if (r < 95) begin
                    send_item(ACT_CLEAR, INDEX_W'($urandom), rand_desc());
                    random_items++;
                end else begin
                    send_item(ACT_UNUSED, INDEX_W'($urandom), rand_desc());
                end
            end
            phase++;
        end
        calm = 1'b0;
    endtask

    // Sequence of tests
    initial begin
        for (int i = 0; i < 64; i++) begin
            pred_map[i]  = '0;
            pred_prev[i] = 0;
        end
        for (int i = 0; i < 17; i++) pred_win[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_map_fill();
        test_default_window();
        test_register_clamps();
        test_clear_and_unknown();
        test_random_traffic();

        wait_idle();
        $display("Run covered %0d input beats (%0d test descriptors) and %0d shift results",
                 beats_sent, tests_sent, results_seen);
        $display("across %0d register settings, with %0d field mismatches.",
                 settings_cnt, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50ms;
        $display("Timeout with %0d results still expected", align_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sequence_hamming_window_matcher_top.f */
rtl/shwm_pkg.sv
rtl/shwm_ctrl.sv
rtl/shwm_datapath.sv
rtl/sequence_hamming_window_matcher_top.sv
tb/tb_sequence_hamming_window_matcher_top.sv
